/* rtl/core/arpc_pkg.sv */
package arpc_pkg;

    localparam int ENTRIES = 64;
    localparam int PENDING = 16;
    localparam int EW = $clog2(ENTRIES);
    localparam int PW = $clog2(PENDING);

    localparam logic [1:0] REQ_LOOKUP = 2'd0;
    localparam logic [1:0] REQ_LEARN  = 2'd1;
    localparam logic [1:0] REQ_QUEUE  = 2'd2;
    localparam logic [1:0] REQ_TICK   = 2'd3;

    localparam logic [2:0] KIND_LOOKUP = 3'd0;
    localparam logic [2:0] KIND_LEARN  = 3'd1;
    localparam logic [2:0] KIND_QUEUE  = 3'd2;
    localparam logic [2:0] KIND_SEND   = 3'd3;
    localparam logic [2:0] KIND_GIVEUP = 3'd4;
    localparam logic [2:0] KIND_TICK   = 3'd5;

    localparam logic [1:0] CFG_LIFETIME = 2'd0;
    localparam logic [1:0] CFG_LIMIT    = 2'd1;
    localparam logic [1:0] CFG_GAP      = 2'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] ip;
        logic [47:0] mac;
    } arpc_in_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic        hit;
        logic [31:0] ip_out;
        logic [47:0] mac_out;
        logic        pending_found;
        logic        stored;
        logic        last;
    } arpc_out_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_ESCAN, ST_PSCAN, ST_EWRITE, ST_PWRITE, ST_DONE
    } arpc_state_t;

    // entry table request from the controller
    typedef struct packed {
        logic          rd;
        logic [EW-1:0] rd_addr;
        logic          wr;
        logic [EW-1:0] wr_addr;
        logic [31:0]   wr_ip;
        logic [47:0]   wr_mac;
        logic [31:0]   wr_added;
    } arpc_ecmd_t;

    typedef struct packed {
        logic          rd;
        logic [PW-1:0] rd_addr;
        logic          wr;
        logic [PW-1:0] wr_addr;
        logic [31:0]   wr_ip;
        logic [31:0]   wr_sent;
        logic [7:0]    wr_count;
        logic          wr_never;
    } arpc_pcmd_t;

endpackage

/* rtl/core/arpc_entry_mem.sv */
module arpc_entry_mem
    import arpc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  arpc_ecmd_t    cmd,
    input  logic          set_valid,
    input  logic          clr_valid,
    input  logic [EW-1:0] clr_addr,
    output logic [ENTRIES-1:0] valid,
    output logic [31:0]   rd_ip,
    output logic [47:0]   rd_mac,
    output logic [31:0]   rd_added
);

    logic [31:0] ip_mem    [ENTRIES];
    logic [47:0] mac_mem   [ENTRIES];
    logic [31:0] added_mem [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;

    assign valid = valid_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            ip_mem[cmd.wr_addr]    <= cmd.wr_ip;
            mac_mem[cmd.wr_addr]   <= cmd.wr_mac;
            added_mem[cmd.wr_addr] <= cmd.wr_added;
        end
        if (cmd.rd)
        begin
            rd_ip    <= ip_mem[cmd.rd_addr];
            rd_mac   <= mac_mem[cmd.rd_addr];
            rd_added <= added_mem[cmd.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
        begin
            if (clr_valid)
                valid_reg[clr_addr] <= 1'b0;
            if (set_valid)
                valid_reg[cmd.wr_addr] <= 1'b1;
        end
    end

endmodule

/* rtl/core/arpc_pend_mem.sv */
module arpc_pend_mem
    import arpc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  arpc_pcmd_t    cmd,
    input  logic          set_valid,
    input  logic          clr_valid,
    input  logic [PW-1:0] clr_addr,
    output logic [PENDING-1:0] valid,
    output logic [31:0]   rd_ip,
    output logic [31:0]   rd_sent,
    output logic [7:0]    rd_count,
    output logic          rd_never
);

    logic [31:0] ip_mem    [PENDING];
    logic [31:0] sent_mem  [PENDING];
    logic [7:0]  count_mem [PENDING];
    logic        never_mem [PENDING];
    logic [PENDING-1:0] valid_reg;

    assign valid = valid_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            ip_mem[cmd.wr_addr]    <= cmd.wr_ip;
            sent_mem[cmd.wr_addr]  <= cmd.wr_sent;
            count_mem[cmd.wr_addr] <= cmd.wr_count;
            never_mem[cmd.wr_addr] <= cmd.wr_never;
        end
        if (cmd.rd)
        begin
            rd_ip    <= ip_mem[cmd.rd_addr];
            rd_sent  <= sent_mem[cmd.rd_addr];
            rd_count <= count_mem[cmd.rd_addr];
            rd_never <= never_mem[cmd.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
        begin
            if (clr_valid)
                valid_reg[clr_addr] <= 1'b0;
            if (set_valid)
                valid_reg[cmd.wr_addr] <= 1'b1;
        end
    end

endmodule

/* rtl/core/arp_cache_with_retry_queue.sv */
// ARP cache with entry aging and a pending-request table.
// Input: start with cmd_in (req_type, ip, mac); taken when start is high and
// busy is low. Results appear on result with strobe high for one cycle each;
// the receiver cannot stall, every strobe is a delivered word.
// Lookup scans all ENTRIES slots through the entry memory, one read per
// cycle. Learn scans PENDING requests, then writes the lowest free entry.
// Queue scans PENDING requests, then takes the lowest free slot if unmatched.
// Tick scans ENTRIES entries for aging, then PENDING requests, giving one
// send word per request due for a resend or one give-up word per request
// past the retry limit, then a tick-done word with last set. Each memory
// has one read and one write port with registered read data.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once.
// Reset empties both tables, zeroes the clock, loads default registers.
module arp_cache_with_retry_queue
    import arpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  arpc_in_t    cmd_in,
    output logic        strobe,
    output arpc_out_t   result,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic [15:0] lifetime_reg;
    logic [7:0]  limit_reg, gap_reg;
    logic [31:0] now_reg, now_next;

    arpc_state_t state_reg, state_next;
    arpc_in_t    item_reg, item_next;
    logic [EW:0] idx_reg, idx_next;       // next read address to issue
    logic        rv_reg, rv_next;         // read data valid this cycle
    logic [EW-1:0] ra_reg, ra_next;       // address of read data
    logic        found_reg, found_next;
    logic [47:0] fmac_reg, fmac_next;
    logic        pf_reg, pf_next;
    logic [PW-1:0] fslot_reg, fslot_next;
    logic        strobe_reg, strobe_next;
    arpc_out_t   res_reg, res_next;

    arpc_ecmd_t ecmd;
    arpc_pcmd_t pcmd;
    logic e_set, e_clr, p_set, p_clr;
    logic [EW-1:0] e_clr_a;
    logic [PW-1:0] p_clr_a;
    logic [ENTRIES-1:0] e_valid;
    logic [PENDING-1:0] p_valid;
    logic [31:0] e_ip, e_added, p_ip, p_sent;
    logic [47:0] e_mac;
    logic [7:0]  p_count;
    logic        p_never;

    logic          e_free_any, p_free_any;
    logic [EW-1:0] e_free;
    logic [PW-1:0] p_free;

    arpc_entry_mem u_emem (
        .clk(clk), .rst_n(rst_n), .cmd(ecmd), .set_valid(e_set),
        .clr_valid(e_clr), .clr_addr(e_clr_a), .valid(e_valid),
        .rd_ip(e_ip), .rd_mac(e_mac), .rd_added(e_added)
    );

    arpc_pend_mem u_pmem (
        .clk(clk), .rst_n(rst_n), .cmd(pcmd), .set_valid(p_set),
        .clr_valid(p_clr), .clr_addr(p_clr_a), .valid(p_valid),
        .rd_ip(p_ip), .rd_sent(p_sent), .rd_count(p_count), .rd_never(p_never)
    );

    // lowest free slot by priority over the valid flops
    always_comb
    begin
        e_free_any = 1'b0;
        e_free = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
            if (!e_valid[i])
            begin
                e_free_any = 1'b1;
                e_free = EW'(i);
            end
        p_free_any = 1'b0;
        p_free = '0;
        for (int i = PENDING - 1; i >= 0; i--)
            if (!p_valid[i])
            begin
                p_free_any = 1'b1;
                p_free = PW'(i);
            end
    end

    assign busy   = (state_reg != ST_IDLE);
    assign strobe = strobe_reg;
    assign result = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lifetime_reg <= 16'd15;
            limit_reg    <= 8'd5;
            gap_reg      <= 8'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LIFETIME: lifetime_reg <= cfg_data;
                CFG_LIMIT:    limit_reg    <= cfg_data[7:0];
                CFG_GAP:      gap_reg      <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            now_reg    <= '0;
            idx_reg    <= '0;
            rv_reg     <= 1'b0;
            found_reg  <= 1'b0;
            pf_reg     <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            now_reg    <= now_next;
            idx_reg    <= idx_next;
            rv_reg     <= rv_next;
            found_reg  <= found_next;
            pf_reg     <= pf_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        ra_reg    <= ra_next;
        fmac_reg  <= fmac_next;
        fslot_reg <= fslot_next;
        res_reg   <= res_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        item_next   = item_reg;
        now_next    = now_reg;
        idx_next    = idx_reg;
        rv_next     = 1'b0;
        ra_next     = ra_reg;
        found_next  = found_reg;
        fmac_next   = fmac_reg;
        pf_next     = pf_reg;
        fslot_next  = fslot_reg;
        strobe_next = 1'b0;
        res_next    = res_reg;
        ecmd  = '0;
        pcmd  = '0;
        e_set = 1'b0;
        e_clr = 1'b0;
        e_clr_a = ra_reg;
        p_set = 1'b0;
        p_clr = 1'b0;
        p_clr_a = ra_reg[PW-1:0];
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    item_next  = cmd_in;
                    idx_next   = '0;
                    found_next = 1'b0;
                    pf_next    = 1'b0;
                    fmac_next  = '0;
                    if (cmd_in.req_type == REQ_LOOKUP)
                        state_next = ST_ESCAN;
                    else if (cmd_in.req_type == REQ_TICK)
                    begin
                        now_next   = now_reg + 32'd1;
                        state_next = ST_ESCAN;
                    end
                    else
                        state_next = ST_PSCAN;
                end
            end
            ST_ESCAN:
            begin
                if (idx_reg < (EW+1)'(ENTRIES))
                begin
                    ecmd.rd      = 1'b1;
                    ecmd.rd_addr = idx_reg[EW-1:0];
                    rv_next      = 1'b1;
                    ra_next      = idx_reg[EW-1:0];
                    idx_next     = idx_reg + 1'b1;
                end
                if (rv_reg && e_valid[ra_reg])
                begin
                    if (item_reg.req_type == REQ_LOOKUP)
                    begin
                        if (e_ip == item_reg.ip)
                        begin
                            found_next = 1'b1;
                            fmac_next  = e_mac;
                        end
                    end
                    else if ((now_reg - e_added) > {16'd0, lifetime_reg})
                        e_clr = 1'b1;
                end
                if (!rv_reg && idx_reg == (EW+1)'(ENTRIES))
                begin
                    idx_next = '0;
                    if (item_reg.req_type == REQ_LOOKUP)
                    begin
                        res_next = '0;
                        res_next.kind = KIND_LOOKUP;
                        res_next.hit  = found_reg;
                        res_next.ip_out = item_reg.ip;
                        res_next.mac_out = found_reg ? fmac_reg : 48'd0;
                        res_next.last = 1'b1;
                        strobe_next = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                        state_next = ST_PSCAN;
                end
            end
            ST_PSCAN:
            begin
                // in learn/queue, stop reading once a match is seen
                if (idx_reg < (EW+1)'(PENDING) && !found_reg)
                begin
                    pcmd.rd      = 1'b1;
                    pcmd.rd_addr = idx_reg[PW-1:0];
                    rv_next      = 1'b1;
                    ra_next      = EW'(idx_reg[PW-1:0]);
                    idx_next     = idx_reg + 1'b1;
                end
                if (rv_reg && p_valid[ra_reg[PW-1:0]])
                begin
                    if (item_reg.req_type != REQ_TICK)
                    begin
                        if (p_ip == item_reg.ip && !found_reg)
                        begin
                            found_next = 1'b1;
                            fslot_next = ra_reg[PW-1:0];
                            rv_next    = 1'b0;
                            idx_next   = (EW+1)'(PENDING);
                        end
                    end
                    else if (p_never || (now_reg - p_sent) > {24'd0, gap_reg})
                    begin
                        pcmd.wr       = 1'b1;
                        pcmd.wr_addr  = ra_reg[PW-1:0];
                        pcmd.wr_ip    = p_ip;
                        pcmd.wr_sent  = now_reg;
                        pcmd.wr_count = (p_count == 8'hFF) ? p_count : p_count + 8'd1;
                        pcmd.wr_never = 1'b0;
                        res_next = '0;
                        res_next.kind = KIND_SEND;
                        res_next.ip_out = p_ip;
                        strobe_next = 1'b1;
                    end
                    else if (p_count >= limit_reg)
                    begin
                        p_clr = 1'b1;
                        res_next = '0;
                        res_next.kind = KIND_GIVEUP;
                        res_next.ip_out = p_ip;
                        strobe_next = 1'b1;
                    end
                end
                if (!rv_reg && idx_reg == (EW+1)'(PENDING))
                begin
                    if (item_reg.req_type == REQ_TICK)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (item_reg.req_type == REQ_LEARN)
                        state_next = ST_EWRITE;
                    else
                        state_next = ST_PWRITE;
                end
                else if (rv_next == 1'b0 && found_next && !found_reg)
                begin
                    state_next = (item_reg.req_type == REQ_LEARN) ? ST_EWRITE
                                                                   : ST_PWRITE;
                end
            end
            ST_EWRITE:
            begin
                p_clr   = found_reg;
                p_clr_a = fslot_reg;
                ecmd.wr       = e_free_any;
                ecmd.wr_addr  = e_free;
                ecmd.wr_ip    = item_reg.ip;
                ecmd.wr_mac   = item_reg.mac;
                ecmd.wr_added = now_reg;
                e_set = e_free_any;
                res_next = '0;
                res_next.kind = KIND_LEARN;
                res_next.ip_out = item_reg.ip;
                res_next.pending_found = found_reg;
                res_next.stored = e_free_any;
                res_next.last = 1'b1;
                strobe_next = 1'b1;
                state_next = ST_IDLE;
            end
            ST_PWRITE:
            begin
                if (!found_reg)
                begin
                    pcmd.wr       = p_free_any;
                    pcmd.wr_addr  = p_free;
                    pcmd.wr_ip    = item_reg.ip;
                    pcmd.wr_sent  = '0;
                    pcmd.wr_count = '0;
                    pcmd.wr_never = 1'b1;
                    p_set = p_free_any;
                end
                res_next = '0;
                res_next.kind = KIND_QUEUE;
                res_next.ip_out = item_reg.ip;
                res_next.pending_found = found_reg;
                res_next.stored = found_reg || p_free_any;
                res_next.last = 1'b1;
                strobe_next = 1'b1;
                state_next = ST_IDLE;
            end
            ST_DONE:
            begin
                res_next = '0;
                res_next.kind = KIND_TICK;
                res_next.last = 1'b1;
                strobe_next = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    a_strobe_kind: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.last |-> !busy)
        else $error("last word while busy");
    a_idle_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !rv_reg)
        else $error("read in flight while idle");
    a_hit_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.hit |-> result.kind == KIND_LOOKUP)
        else $error("hit on non-lookup word");
    a_tick_time: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && cmd_in.req_type == REQ_TICK |=> now_reg == $past(now_reg) + 32'd1)
        else $error("tick did not advance time");

endmodule
